FILE: rtl/core/keyframe_linear_interpolator_defines.svh
// Assertion macros for the keyframe interpolator.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication.
`define KLI_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define KLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/kli_pkg.sv
package kli_pkg;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] MODE_HOLD    = 2'd0;
    localparam logic [1:0] MODE_SAW     = 2'd1;
    localparam logic [1:0] MODE_TRI     = 2'd2;
    localparam logic [1:0] MODE_SAW_ALT = 2'd3;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CAPTURE,
        OP_SET_RANGE,
        OP_SET_FULL,
        OP_WR_VAL,
        OP_SET_POS,
        OP_SET_POS_END,
        OP_SHIFT_INIT,
        OP_SHIFT,
        OP_INSERT,
        OP_RES_V0,
        OP_DIV_WRAP,
        OP_WRAP_APPLY,
        OP_ADJUST,
        OP_KEEP_PREV,
        OP_ADVANCE,
        OP_LERP_MUL,
        OP_DIV_LERP,
        OP_LERP_FIN,
        OP_NOT_FOUND
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic range_bad;
        logic cnt_zero;
        logic cnt_one;
        logic cnt_full;
        logic key_eq;
        logic key_gt;
        logic at_last;
        logic at_pos;
        logic wrap;
        logic below_first;
        logic seg_hit;
        logic div_done;
    } t_stat;

endpackage

FILE: rtl/core/kli_ram.sv
module kli_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/kli_div.sv
module kli_div #(
    parameter int DW = 40,
    parameter int SW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [SW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [SW-1:0] o_rem
);

    localparam int CW = $clog2(DW + 1);

    logic [SW-1:0] r_d, n_d;
    logic [SW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_q, n_q;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_run, n_run;
    logic          r_done, n_done;
    logic [SW:0]   trial;

    always_comb begin
        n_d    = r_d;
        n_rem  = r_rem;
        n_q    = r_q;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = r_done;
        trial  = {r_rem, r_q[DW-1]};
        if (i_start) begin
            n_d    = i_divisor;
            n_rem  = '0;
            n_q    = i_dividend;
            n_cnt  = CW'(DW);
            n_run  = 1'b1;
            n_done = 1'b0;
        end else if (r_run) begin
            if (trial >= {1'b0, r_d}) begin
                n_rem = SW'(trial - {1'b0, r_d});
                n_q   = {r_q[DW-2:0], 1'b1};
            end else begin
                n_rem = trial[SW-1:0];
                n_q   = {r_q[DW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
        end
        r_d   <= n_d;
        r_rem <= n_rem;
        r_q   <= n_q;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/core/kli_datapath.sv
module kli_datapath #(
    parameter int MAX_POINTS = 16,
    parameter int TIME_BITS  = 24,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_wdata,
    input  logic [1:0]                   i_req_type,
    input  logic signed [31:0]           i_sample_time,
    input  logic signed [VALUE_BITS-1:0] i_point_value,
    input  kli_pkg::t_cmd                i_cmd,
    output kli_pkg::t_stat               o_stat,
    output logic signed [VALUE_BITS-1:0] o_result_value,
    output logic [1:0]                   o_status
);

    import kli_pkg::*;

    localparam int TB    = TIME_BITS;
    localparam int VB    = VALUE_BITS;
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int PW    = TB + VB;
    localparam int DW    = (PW > 32) ? PW : 32;

    logic [1:0]      r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    logic [TB-1:0]   r_last, n_last;
    logic [31:0]     r_t, n_t;
    logic [VB-1:0]   r_v, n_v;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic            r_par, n_par;
    logic [TB-1:0]   r_prev_time, n_prev_time;
    logic [VB-1:0]   r_prev_val, n_prev_val;
    logic [PW-1:0]   r_prod, n_prod;
    logic [TB-1:0]   r_span, n_span;
    logic [VB-1:0]   r_v0, n_v0;
    logic            r_sgn, n_sgn;
    logic [VB-1:0]   r_result, n_result;
    logic [1:0]      r_status, n_status;

    logic            we;
    logic [PW-1:0]   wdata;
    logic [PW-1:0]   rdata;
    logic [IDX_W-1:0] rd_addr;
    logic [TB-1:0]   rd_time;
    logic [VB-1:0]   rd_val;
    logic            div_start;
    logic [DW-1:0]   div_dividend;
    logic [TB-1:0]   div_divisor;
    logic            div_done;
    logic [DW-1:0]   div_quot;
    logic [TB-1:0]   div_rem;
    logic [31:0]     t_clamp;
    logic [TB-1:0]   dt;
    logic [VB:0]     vdiff;
    logic [VB-1:0]   vmag;

    assign rd_time = rdata[PW-1:VB];
    assign rd_val  = rdata[VB-1:0];
    assign rd_addr = (i_cmd.op == OP_SHIFT_INIT || i_cmd.op == OP_SHIFT) ? n_idx - 1'b1 : n_idx;

    kli_ram #(
        .WIDTH(PW),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_idx),
        .i_wdata(wdata),
        .i_raddr(rd_addr),
        .o_rdata(rdata)
    );

    kli_div #(
        .DW(DW),
        .SW(TB)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quot    (div_quot),
        .o_rem     (div_rem)
    );

    assign t_clamp     = r_t[31] ? '0 : r_t;
    assign dt          = r_t[TB-1:0] - r_prev_time;
    assign vdiff       = {rd_val[VB-1], rd_val} - {r_prev_val[VB-1], r_prev_val};
    assign vmag        = vdiff[VB] ? VB'(-vdiff) : vdiff[VB-1:0];
    assign div_divisor = (i_cmd.op == OP_DIV_WRAP) ? r_last : r_span;

    always_comb begin
        o_stat.range_bad   = (r_t[31:TB] != '0);
        o_stat.cnt_zero    = (r_count == '0);
        o_stat.cnt_one     = (r_count == CNT_W'(1));
        o_stat.cnt_full    = (r_count == CNT_W'(MAX_POINTS));
        o_stat.key_eq      = (rd_time == r_t[TB-1:0]);
        o_stat.key_gt      = (rd_time > r_t[TB-1:0]);
        o_stat.at_last     = (CNT_W'(r_idx) == r_count - 1'b1);
        o_stat.at_pos      = (r_idx == r_pos);
        o_stat.wrap        = (r_mode != MODE_HOLD) && (r_last != '0)
                             && ($signed(r_t) > $signed(32'(r_last)));
        o_stat.below_first = (r_mode == MODE_HOLD) && ($signed(r_t) < $signed(32'(rd_time)));
        o_stat.seg_hit     = (32'(r_prev_time) <= r_t) && (32'(rd_time) >= r_t);
        o_stat.div_done    = div_done;
    end

    always_comb begin
        n_mode      = i_cfg_we ? i_cfg_wdata : r_mode;
        n_count     = r_count;
        n_last      = r_last;
        n_t         = r_t;
        n_v         = r_v;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_par       = r_par;
        n_prev_time = r_prev_time;
        n_prev_val  = r_prev_val;
        n_prod      = r_prod;
        n_span      = r_span;
        n_v0        = r_v0;
        n_sgn       = r_sgn;
        n_result    = r_result;
        n_status    = r_status;
        we          = 1'b0;
        wdata       = {rd_time, r_v};
        div_start   = 1'b0;
        div_dividend = DW'(r_prod);
        unique case (i_cmd.op)
            OP_CAPTURE: begin
                n_t      = i_sample_time;
                n_v      = i_point_value;
                n_idx    = '0;
                n_par    = 1'b0;
                n_result = '0;
                n_status = ST_OK;
                if (i_req_type == REQ_CLEAR) begin
                    n_count = '0;
                    n_last  = '0;
                end
            end
            OP_SET_RANGE:   n_status = ST_RANGE;
            OP_SET_FULL:    n_status = ST_FULL;
            OP_WR_VAL:      we = 1'b1;
            OP_SET_POS:     n_pos = r_idx;
            OP_SET_POS_END: n_pos = r_count[IDX_W-1:0];
            OP_SHIFT_INIT:  n_idx = r_count[IDX_W-1:0];
            OP_SHIFT: begin
                we    = 1'b1;
                wdata = rdata;
                n_idx = r_idx - 1'b1;
            end
            OP_INSERT: begin
                we      = 1'b1;
                wdata   = {r_t[TB-1:0], r_v};
                n_count = r_count + 1'b1;
                if (r_t[TB-1:0] > r_last) begin
                    n_last = r_t[TB-1:0];
                end
            end
            OP_RES_V0:   n_result = rd_val;
            OP_DIV_WRAP: begin
                div_start    = 1'b1;
                div_dividend = DW'(r_t);
            end
            OP_WRAP_APPLY: begin
                n_t   = 32'(div_rem);
                n_par = div_quot[0];
            end
            OP_ADJUST: begin
                n_idx = '0;
                if (r_mode == MODE_TRI && r_par) begin
                    n_t = 32'(r_last) - t_clamp;
                end else begin
                    n_t = t_clamp;
                end
            end
            OP_KEEP_PREV, OP_ADVANCE: begin
                n_prev_time = rd_time;
                n_prev_val  = rd_val;
                n_idx       = r_idx + 1'b1;
            end
            OP_LERP_MUL: begin
                n_prod = PW'(dt) * PW'(vmag);
                n_span = rd_time - r_prev_time;
                n_v0   = r_prev_val;
                n_sgn  = vdiff[VB];
            end
            OP_DIV_LERP: div_start = 1'b1;
            OP_LERP_FIN: begin
                n_result = r_sgn ? r_v0 - div_quot[VB-1:0] : r_v0 + div_quot[VB-1:0];
            end
            OP_NOT_FOUND: n_result = (r_mode == MODE_HOLD) ? rd_val : '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TRI;
            r_count <= '0;
            r_last  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
            r_last  <= n_last;
        end
        r_t         <= n_t;
        r_v         <= n_v;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_par       <= n_par;
        r_prev_time <= n_prev_time;
        r_prev_val  <= n_prev_val;
        r_prod      <= n_prod;
        r_span      <= n_span;
        r_v0        <= n_v0;
        r_sgn       <= n_sgn;
        r_result    <= n_result;
        r_status    <= n_status;
    end

    assign o_result_value = r_result;
    assign o_status       = r_status;

endmodule

FILE: rtl/core/kli_ctrl.sv
module kli_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [1:0]     i_req_type,
    input  kli_pkg::t_stat i_stat,
    output kli_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_valid
);

    import kli_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_ADD_FULL,
        S_ADD_SHIFT,
        S_Q_CHECK,
        S_Q_WDIV,
        S_Q_ADJ,
        S_Q_FIRST,
        S_Q_SCAN,
        S_Q_MUL,
        S_Q_LDIV
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    t_op    op;

    always_comb begin
        n_state = r_state;
        op      = OP_IDLE;
        n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op = OP_CAPTURE;
                    case (i_req_type)
                        REQ_ADD:   n_state = S_ADD_SCAN;
                        REQ_QUERY: n_state = S_Q_CHECK;
                        default:   n_valid = 1'b1;
                    endcase
                end
            end
            S_ADD_SCAN: begin
                if (i_stat.range_bad) begin
                    op      = OP_SET_RANGE;
                    n_valid = 1'b1;
                end else if (i_stat.cnt_zero) begin
                    op      = OP_SET_POS_END;
                    n_state = S_ADD_FULL;
                end else if (i_stat.key_eq) begin
                    op      = OP_WR_VAL;
                    n_valid = 1'b1;
                end else if (i_stat.key_gt) begin
                    op      = OP_SET_POS;
                    n_state = S_ADD_FULL;
                end else if (i_stat.at_last) begin
                    op      = OP_SET_POS_END;
                    n_state = S_ADD_FULL;
                end else begin
                    op = OP_ADVANCE;
                end
            end
            S_ADD_FULL: begin
                if (i_stat.cnt_full) begin
                    op      = OP_SET_FULL;
                    n_valid = 1'b1;
                end else begin
                    op      = OP_SHIFT_INIT;
                    n_state = S_ADD_SHIFT;
                end
            end
            S_ADD_SHIFT: begin
                if (i_stat.at_pos) begin
                    op      = OP_INSERT;
                    n_valid = 1'b1;
                end else begin
                    op = OP_SHIFT;
                end
            end
            S_Q_CHECK: begin
                if (i_stat.cnt_zero) begin
                    n_valid = 1'b1;
                end else if (i_stat.cnt_one) begin
                    op      = OP_RES_V0;
                    n_valid = 1'b1;
                end else if (i_stat.wrap) begin
                    op      = OP_DIV_WRAP;
                    n_state = S_Q_WDIV;
                end else begin
                    op      = OP_ADJUST;
                    n_state = S_Q_FIRST;
                end
            end
            S_Q_WDIV: begin
                if (i_stat.div_done) begin
                    op      = OP_WRAP_APPLY;
                    n_state = S_Q_ADJ;
                end
            end
            S_Q_ADJ: begin
                op      = OP_ADJUST;
                n_state = S_Q_FIRST;
            end
            S_Q_FIRST: begin
                if (i_stat.below_first) begin
                    op      = OP_RES_V0;
                    n_valid = 1'b1;
                end else begin
                    op      = OP_KEEP_PREV;
                    n_state = S_Q_SCAN;
                end
            end
            S_Q_SCAN: begin
                if (i_stat.seg_hit) begin
                    op      = OP_LERP_MUL;
                    n_state = S_Q_MUL;
                end else if (i_stat.at_last) begin
                    op      = OP_NOT_FOUND;
                    n_valid = 1'b1;
                end else begin
                    op = OP_ADVANCE;
                end
            end
            S_Q_MUL: begin
                op      = OP_DIV_LERP;
                n_state = S_Q_LDIV;
            end
            S_Q_LDIV: begin
                if (i_stat.div_done) begin
                    op      = OP_LERP_FIN;
                    n_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (n_valid) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_cmd.op = op;
    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;

endmodule

FILE: rtl/core/keyframe_linear_interpolator.sv
// Keyframe table with linear interpolation. A request is taken when start is high and busy
// is low; its single result appears on o_result_value/o_status for exactly one cycle with
// o_result_valid, and the receiver cannot stall it, so it must be captured then. Clear and
// the unused request code raise o_result_valid in the cycle after they are taken. An add
// walks the sorted table one entry per cycle up to the insert point and then shifts the
// entries above it one per cycle. A query scans the table one entry per cycle and runs the
// shared bit-serial divider once to wrap a time past the latest key (outside hold mode) and
// once to interpolate the segment that it finds. The table needs no clearing after reset.
module keyframe_linear_interpolator #(
    parameter int MAX_POINTS = 16,
    parameter int TIME_BITS  = 24,
    parameter int VALUE_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_wdata,
    input  logic [1:0]                   i_req_type,
    input  logic signed [31:0]           i_sample_time,
    input  logic signed [VALUE_BITS-1:0] i_point_value,
    output logic                         o_result_valid,
    output logic signed [VALUE_BITS-1:0] o_result_value,
    output logic [1:0]                   o_status
);

    import kli_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    kli_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_req_type(i_req_type),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_busy    (busy),
        .o_valid   (o_result_valid)
    );

    kli_datapath #(
        .MAX_POINTS(MAX_POINTS),
        .TIME_BITS (TIME_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_sample_time (i_sample_time),
        .i_point_value (i_point_value),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_result_value(o_result_value),
        .o_status      (o_status)
    );

endmodule

FILE: rtl/core/kli_checker.sv
`include "keyframe_linear_interpolator_defines.svh"

module kli_checker #(
    parameter int VALUE_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   i_req_type,
    input logic                         o_result_valid,
    input logic signed [VALUE_BITS-1:0] o_result_value,
    input logic [1:0]                   o_status
);

    import kli_pkg::*;

    logic accept_short;
    logic accept_long;
    logic result_err;

    assign accept_short = start && !busy && (i_req_type == REQ_CLEAR || i_req_type == REQ_NOP);
    assign accept_long  = start && !busy && (i_req_type == REQ_ADD || i_req_type == REQ_QUERY);
    assign result_err   = o_result_valid && (o_status != ST_OK);

    `KLI_ASSERT_NEXT(a_quick_done, i_clk, i_rst_n, accept_short, o_result_valid)
    `KLI_ASSERT_NEXT(a_long_busy, i_clk, i_rst_n, accept_long, busy)
    `KLI_ASSERT_IMP(a_done_on_fall, i_clk, i_rst_n, $fell(busy), o_result_valid)
    `KLI_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, result_err, o_result_value == '0)

endmodule

bind keyframe_linear_interpolator kli_checker #(.VALUE_BITS(VALUE_BITS)) u_kli_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_req_type    (i_req_type),
    .o_result_valid(o_result_valid),
    .o_result_value(o_result_value),
    .o_status      (o_status)
);

FILE: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kli_pkg::*;

    localparam int NPTS = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic signed [15:0] value;
        logic [1:0]         status;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_wdata = '0;
    logic [1:0]         i_req_type = '0;
    logic signed [31:0] i_sample_time = '0;
    logic signed [15:0] i_point_value = '0;
    logic               o_result_valid;
    logic signed [15:0] o_result_value;
    logic [1:0]         o_status;

    logic [23:0]        key_time_tbl [NPTS];
    logic signed [15:0] key_value_tbl [NPTS];
    int                 key_total;
    logic [23:0]        top_time;
    logic [1:0]         mode_reg;

    t_outcome pending_q[$];
    int       n_errors;
    int       n_requests;
    int       n_queries;
    int       idle_cycles;
    bit       calm;

    keyframe_linear_interpolator u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (i_req_type),
        .i_sample_time  (i_sample_time),
        .i_point_value  (i_point_value),
        .o_result_valid (o_result_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [1:0] store_point(longint t, logic signed [15:0] v);
        int pos;
        pos = key_total;
        if (t < 0 || t >= (64'sd1 <<< 24)) begin
            return ST_RANGE;
        end
        for (int i = 0; i < key_total; i++) begin
            if (key_time_tbl[i] == t) begin
                key_value_tbl[i] = v;
                return ST_OK;
            end
            if (key_time_tbl[i] > t) begin
                pos = i;
                break;
            end
        end
        if (key_total >= NPTS) begin
            return ST_FULL;
        end
        for (int i = key_total; i > pos; i--) begin
            key_time_tbl[i] = key_time_tbl[i-1];
            key_value_tbl[i] = key_value_tbl[i-1];
        end
        key_time_tbl[pos] = t[23:0];
        key_value_tbl[pos] = v;
        key_total++;
        if (t[23:0] > top_time) begin
            top_time = t[23:0];
        end
        return ST_OK;
    endfunction

    function automatic longint blend(int i, longint t);
        longint dt, span, v0, v1;
        dt = t - longint'(key_time_tbl[i]);
        span = longint'(key_time_tbl[i+1]) - longint'(key_time_tbl[i]);
        v0 = key_value_tbl[i];
        v1 = key_value_tbl[i+1];
        if (span == 0) begin
            return v0;
        end
        if (v1 >= v0) begin
            return v0 + (dt * (v1 - v0)) / span;
        end
        return v0 - (dt * (v0 - v1)) / span;
    endfunction

    function automatic longint sample_curve(longint t);
        bit     odd;
        longint maxt;
        odd = 0;
        maxt = top_time;
        if (key_total == 0) begin
            return 0;
        end
        if (key_total == 1) begin
            return key_value_tbl[0];
        end
        if (mode_reg != MODE_HOLD && t > maxt && maxt > 0) begin
            odd = (t / maxt) & 1;
            t = t % maxt;
        end
        if (t < 0) begin
            t = 0;
        end
        if (mode_reg == MODE_TRI && odd) begin
            t = maxt - t;
        end
        if (mode_reg == MODE_HOLD && t < key_time_tbl[0]) begin
            return key_value_tbl[0];
        end
        for (int i = 0; i + 1 < key_total; i++) begin
            if (key_time_tbl[i] <= t && key_time_tbl[i+1] >= t) begin
                return blend(i, t);
            end
        end
        if (mode_reg == MODE_HOLD) begin
            return key_value_tbl[key_total-1];
        end
        return 0;
    endfunction

    task automatic send_request(logic [1:0] kind, logic signed [31:0] t, logic signed [15:0] v);
        t_outcome exp;
        while (!calm && $urandom_range(99) < 21) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= kind;
        i_sample_time <= t;
        i_point_value <= v;
        do @(posedge i_clk); while (busy);
        exp.value = '0;
        exp.status = ST_OK;
        case (kind)
            REQ_ADD: begin
                exp.status = store_point(t, v);
            end
            REQ_CLEAR: begin
                key_total = 0;
                top_time = '0;
            end
            REQ_QUERY: begin
                exp.value = 16'(sample_curve(t));
                n_queries++;
            end
            default: ;
        endcase
        pending_q.push_back(exp);
        n_requests++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_set_mode(logic [1:0] m);
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_q.size() != 0 && guard < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (120) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mode_reg = m;
    endtask

    always @(posedge i_clk) begin
        t_outcome exp;
        if (i_rst_n && o_result_valid) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result value=%0d status=%0d", $time,
                         o_result_value, o_status);
                n_errors++;
            end else begin
                exp = pending_q.pop_front();
                if (o_result_value !== exp.value) begin
                    $display("%0t: result_value expected %0d actual %0d", $time,
                             exp.value, o_result_value);
                    n_errors++;
                end
                if (o_status !== exp.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp.status, o_status);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_result_valid || (start && !busy)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d requests", n_requests);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic signed [31:0] pick_time();
        case ($urandom_range(9))
            0: return $urandom;
            1: return -$signed(32'($urandom_range(1000)));
            2: return 32'($urandom_range(16777215));
            3: return 32'(top_time) + $urandom_range(2);
            default: return 32'($urandom_range(int'(top_time) * 3 + 10));
        endcase
    endfunction

    task automatic test_directed();
        send_request(REQ_QUERY, 32'sd5, 16'sd0);
        send_request(REQ_ADD, 32'sd100, 16'sh7fff);
        send_request(REQ_QUERY, 32'sd7, 16'sd0);
        send_request(REQ_ADD, 32'sd0, -16'sh8000);
        send_request(REQ_ADD, 32'sd50, 16'sd256);
        send_request(REQ_ADD, 32'sd50, -16'sd300);
        send_request(REQ_ADD, -32'sd1, 16'sd1);
        send_request(REQ_ADD, 32'sh0100_0000, 16'sd1);
        send_request(REQ_ADD, 32'sh7fff_ffff, 16'sd1);
        send_request(REQ_ADD, 32'sh00ff_ffff, 16'sd1);
        send_request(REQ_QUERY, 32'sd25, 16'sd0);
        send_request(REQ_QUERY, 32'sd75, 16'sd0);
        send_request(REQ_QUERY, -32'sh8000_0000, 16'sd0);
        send_request(REQ_QUERY, 32'sh7fff_ffff, 16'sd0);
        send_request(REQ_NOP, 32'sd3, 16'sd3);
        send_request(REQ_CLEAR, 32'sd0, 16'sd0);
        for (int i = 0; i < 17; i++) begin
            send_request(REQ_ADD, 32'(10 + i * 7), 16'(i * 1000 - 8000));
        end
        send_request(REQ_ADD, 32'sd17, 16'sd42);
        send_request(REQ_QUERY, 32'sd5, 16'sd0);
        send_request(REQ_QUERY, 32'sd300, 16'sd0);
    endtask

    task automatic test_random_mode(logic [1:0] m, int count);
        drain_and_set_mode(m);
        for (int n = 0; n < count; n++) begin
            calm = (n >= count / 3 && n < count / 2);
            case ($urandom_range(19))
                0: send_request(REQ_CLEAR, $urandom, 16'($urandom));
                1: send_request(REQ_NOP, $urandom, 16'($urandom));
                2, 3, 4, 5: send_request(REQ_ADD, ($urandom_range(9) == 0) ? $urandom :
                                         32'($urandom_range(4000)), 16'($urandom));
                default: send_request(REQ_QUERY, pick_time(), 16'($urandom));
            endcase
        end
        calm = 0;
    endtask

    initial begin
        n_errors = 0;
        n_requests = 0;
        n_queries = 0;
        idle_cycles = 0;
        calm = 0;
        key_total = 0;
        top_time = '0;
        mode_reg = MODE_TRI;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        drain_and_set_mode(MODE_HOLD);
        test_directed();
        test_random_mode(MODE_HOLD, 220);
        test_random_mode(MODE_SAW, 220);
        test_random_mode(MODE_TRI, 220);
        test_random_mode(MODE_SAW_ALT, 150);
        drain_and_set_mode(MODE_TRI);
        $display("covered %0d requests (%0d queries) over hold, sawtooth, triangle and mode 3",
                 n_requests, n_queries);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
